// ----- hdl/u8v_pkg.sv -----
// shared types and constants for the utf-8 stream validator
`default_nettype none

package u8v_pkg;

   // input word: one byte of the string plus end-of-string mark
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   // result word: one verdict per string
   typedef struct packed {
      logic        found_invalid;
      logic [31:0] error_offset;
   } rsp_type;

   // range rule for the second byte of a multi-byte sequence
   localparam logic [1:0] RULE_NONE   = 2'd0;  // any continuation byte
   localparam logic [1:0] RULE_MIN_A0 = 2'd1;  // e0 lead, second >= a0
   localparam logic [1:0] RULE_MIN_90 = 2'd2;  // f0 lead, second >= 90
   localparam logic [1:0] RULE_MAX_8F = 2'd3;  // f4 lead, second <= 8f

   localparam logic CSR_STRICT_RESET = 1'b1;

endpackage

`default_nettype wire

// ----- hdl/u8v_in_stage.sv -----
// input register holding one accepted byte word until the checker takes it
`default_nettype none

module u8v_in_stage (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire u8v_pkg::req_type req_data,
   input  wire logic             item_take,
   output logic                  item_valid,
   output u8v_pkg::req_type      item_data
);
   import u8v_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type data_ff;
   logic    accept;

   // hold off the sender only while a word sits here that cannot move on
   assign req_stall = valid_ff && !item_take;
   assign accept    = req_valid && !req_stall;

   // occupancy of the register
   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (item_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload register, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= req_data;
      end
   end

   assign item_valid = valid_ff;
   assign item_data  = data_ff;

endmodule

`default_nettype wire

// ----- hdl/u8v_check.sv -----
// sequence tracking, error latch and result register of the utf-8 validator
`default_nettype none

module u8v_check #(
   parameter int OFFSET_BITS = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_valid,
   input  wire logic             csr_data,
   input  wire logic             item_valid,
   input  wire u8v_pkg::req_type item_data,
   output logic                  item_take,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output u8v_pkg::rsp_type      rsp_data
);
   import u8v_pkg::*;

   localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

   logic                   strict_ff;
   logic [OFFSET_BITS-1:0] offset_ff,  offset_in;
   logic [OFFSET_BITS-1:0] start_ff,   start_in;
   logic [1:0]             remain_ff,  remain_in;
   logic [1:0]             rule_ff,    rule_in;
   logic                   second_ff,  second_in;
   logic                   err_ff,     err_in;
   logic [OFFSET_BITS-1:0] errpos_ff,  errpos_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff,  rsp_data_in;

   logic [7:0] b;
   logic       out_free;
   logic       cont_ok;
   logic       second_ok;

   assign b = item_data.data_byte;

   // mode register; the user must write it only while the block is idle, the block itself does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         strict_ff <= CSR_STRICT_RESET;
      end else if (csr_valid) begin
         strict_ff <= csr_data;
      end
   end

   // a non-final word never needs the result slot
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign item_take = item_valid && (!item_data.last_byte || out_free);

   // second-byte range check
   always_comb begin
      case (rule_ff)
         RULE_MIN_A0: second_ok = (b >= 8'hA0);
         RULE_MIN_90: second_ok = (b >= 8'h90);
         RULE_MAX_8F: second_ok = (b <= 8'h8F);
         default:     second_ok = 1'b1;
      endcase
   end

   assign cont_ok = (b[7:6] == 2'b10) && (!second_ff || second_ok);

   // next state for the word in the input register
   always_comb begin
      offset_in = offset_ff;
      start_in  = start_ff;
      remain_in = remain_ff;
      rule_in   = rule_ff;
      second_in = second_ff;
      err_in    = err_ff;
      errpos_in = errpos_ff;

      if (!err_ff) begin
         if (remain_ff != 2'd0) begin
            // continuation byte expected
            if (!cont_ok) begin
               err_in    = 1'b1;
               errpos_in = start_ff;
               remain_in = 2'd0;
            end else begin
               remain_in = remain_ff - 2'd1;
            end
            second_in = 1'b0;
            rule_in   = RULE_NONE;
         end else begin
            // lead byte
            start_in  = offset_ff;
            remain_in = 2'd0;
            rule_in   = RULE_NONE;
            second_in = 1'b0;
            if (b inside {[8'h80:8'hBF]}) begin
               if (strict_ff) begin
                  err_in    = 1'b1;
                  errpos_in = offset_ff;
               end
            end else if (b inside {[8'hC0:8'hC1], [8'hF5:8'hF7]}) begin
               err_in    = 1'b1;
               errpos_in = offset_ff;
            end else if (b inside {[8'hC2:8'hDF]}) begin
               remain_in = 2'd1;
               second_in = 1'b1;
            end else if (b inside {[8'hE0:8'hEF]}) begin
               remain_in = 2'd2;
               second_in = 1'b1;
               if (b == 8'hE0) begin
                  rule_in = RULE_MIN_A0;
               end
            end else if (b inside {[8'hF0:8'hF4]}) begin
               remain_in = 2'd3;
               second_in = 1'b1;
               if (b == 8'hF0) begin
                  rule_in = RULE_MIN_90;
               end else if (b == 8'hF4) begin
                  rule_in = RULE_MAX_8F;
               end
            end else if (b inside {[8'hF8:8'hFF]}) begin
               if (strict_ff) begin
                  err_in    = 1'b1;
                  errpos_in = offset_ff;
               end
            end
         end
      end

      // truncated sequence at end of string
      if (item_data.last_byte && !err_in && remain_in != 2'd0) begin
         err_in    = 1'b1;
         errpos_in = start_in;
      end

      // verdict from the updated latch
      rsp_data_in.found_invalid = err_in;
      rsp_data_in.error_offset  = err_in ? 32'(errpos_in) : 32'd0;

      if (item_data.last_byte) begin
         // string done, back to the start state
         offset_in = '0;
         start_in  = '0;
         remain_in = 2'd0;
         rule_in   = RULE_NONE;
         second_in = 1'b0;
         err_in    = 1'b0;
         errpos_in = '0;
      end else if (offset_ff != OFFSET_MAX) begin
         offset_in = offset_ff + 1'b1;
      end
   end

   // result slot occupancy
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (item_take && item_data.last_byte) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // string state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff    <= '0;
         start_ff     <= '0;
         remain_ff    <= 2'd0;
         rule_ff      <= RULE_NONE;
         second_ff    <= 1'b0;
         err_ff       <= 1'b0;
         errpos_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (item_take) begin
            offset_ff <= offset_in;
            start_ff  <= start_in;
            remain_ff <= remain_in;
            rule_ff   <= rule_in;
            second_ff <= second_in;
            err_ff    <= err_in;
            errpos_ff <= errpos_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (item_take && item_data.last_byte) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a new verdict only follows a final word
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(item_take && item_data.last_byte))
      else $error("verdict without a final word");

   // a valid string reports offset zero
   a_valid_zero_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.found_invalid |-> rsp_data_ff.error_offset == 32'd0)
      else $error("nonzero offset on a valid string");

   // end of string returns the counter to zero
   a_offset_cleared: assert property (@(posedge clock) disable iff (reset)
      item_take && item_data.last_byte |=> offset_ff == '0 && !err_ff)
      else $error("string state not cleared");

   // no open sequence once an error is latched
   a_no_open_after_err: assert property (@(posedge clock) disable iff (reset)
      err_ff |-> remain_ff == 2'd0 && !second_ff)
      else $error("open sequence with latched error");

endmodule

`default_nettype wire

// ----- hdl/utf8_stream_validator_top.sv -----
// top level of the utf-8 stream validator
// a final word's verdict is registered on rsp_valid when the checker takes the word
// throughput: one word per cycle, the string state updates in a single registered step,
// but a final word waits in the input register, only while the result register is stalled
// reset (synchronous, active high) clears all string state and sets strict mode
`default_nettype none

module utf8_stream_validator_top #(
   parameter int OFFSET_BITS = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire u8v_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output u8v_pkg::rsp_type      rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic             csr_data
);
   import u8v_pkg::*;

   logic    item_valid;
   logic    item_take;
   req_type item_data;

   // mode register always accepts
   assign csr_ready = 1'b1;

   // input register
   u8v_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .item_take  (item_take),
      .item_valid (item_valid),
      .item_data  (item_data)
   );

   // checker and result register
   u8v_check #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_check (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid && csr_ready),
      .csr_data   (csr_data),
      .item_valid (item_valid),
      .item_data  (item_data),
      .item_take  (item_take),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

// ----- sim/tb_utf8_stream_validator_top.sv -----
// testbench for the utf-8 stream validator: directed and random byte strings against a verdict predictor
`timescale 1ns / 1ps

module tb_utf8_stream_validator_top;
   import u8v_pkg::*;

   localparam int CLOCK_HALF = 5;
   localparam longint RUN_LIMIT_NS = 64'd5_000_000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic    csr_data;

   // predictor copy of the register and the per-string state
   logic        strict_cfg;
   logic [31:0] cur_offset;
   logic [31:0] lead_offset;
   logic [1:0]  owed;
   logic [1:0]  second_rule;
   logic        second_pending;
   logic        bad_seen;
   logic [31:0] bad_offset;

   rsp_type    verdict_q[$];
   rsp_type    want_verdict;
   logic [7:0] pending_bytes[$];
   int         fail_count = 0;
   int         words_sent = 0;
   int         stall_left = 0;
   bit         quiet_run = 1'b0;

   utf8_stream_validator_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #CLOCK_HALF clock = ~clock;

   // run limit
   initial begin
      #(RUN_LIMIT_NS);
      $display("TEST FAILED");
      $finish;
   end

   // gap length: mostly none or short, now and then long
   function automatic int pick_gap();
      int roll;
      if (quiet_run) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      else if (roll < 90) return $urandom_range(1, 3);
      else if (roll < 97) return $urandom_range(4, 10);
      else return $urandom_range(20, 40);
   endfunction

   function automatic logic [7:0] cont_byte();
      return 8'($urandom_range(8'h80, 8'hBF));
   endfunction

   task automatic clear_string_state();
      cur_offset = '0;
      lead_offset = '0;
      owed = '0;
      second_rule = RULE_NONE;
      second_pending = 1'b0;
      bad_seen = 1'b0;
      bad_offset = '0;
   endtask

   task automatic mark_bad(input logic [31:0] where);
      bad_seen = 1'b1;
      bad_offset = where;
      owed = '0;
      second_pending = 1'b0;
      second_rule = RULE_NONE;
   endtask

   // advance the predicted string state by one accepted byte
   task automatic predict_verdict(input logic [7:0] b, input logic is_last);
      logic       ok;
      logic       rejected;
      logic [1:0] need;
      logic [1:0] rule;
      rsp_type    v;
      if (!bad_seen) begin
         if (owed != 0) begin
            // continuation byte, with the range rule on the second byte
            ok = (b[7:6] == 2'b10);
            if (ok && second_pending) begin
               case (second_rule)
                  RULE_MIN_A0: ok = (b >= 8'hA0);
                  RULE_MIN_90: ok = (b >= 8'h90);
                  RULE_MAX_8F: ok = (b <= 8'h8F);
                  default:     ok = 1'b1;
               endcase
            end
            if (!ok) mark_bad(lead_offset);
            else begin
               owed = owed - 2'd1;
               second_pending = 1'b0;
               second_rule = RULE_NONE;
            end
         end else begin
            // lead byte decode
            lead_offset = cur_offset;
            need = 2'd0;
            rule = RULE_NONE;
            rejected = 1'b0;
            if (b < 8'h80) need = 2'd0;
            else if (b <= 8'hBF) rejected = strict_cfg;
            else if (b <= 8'hC1) rejected = 1'b1;
            else if (b <= 8'hDF) need = 2'd1;
            else if (b <= 8'hEF) begin
               need = 2'd2;
               if (b == 8'hE0) rule = RULE_MIN_A0;
            end else if (b <= 8'hF4) begin
               need = 2'd3;
               if (b == 8'hF0) rule = RULE_MIN_90;
               else if (b == 8'hF4) rule = RULE_MAX_8F;
            end else if (b <= 8'hF7) rejected = 1'b1;
            else rejected = strict_cfg;
            if (rejected) mark_bad(cur_offset);
            else begin
               owed = need;
               second_rule = rule;
               second_pending = (need != 0);
            end
         end
      end
      if (is_last) begin
         // sequence cut off by the end of the string
         if (!bad_seen && owed != 0) mark_bad(lead_offset);
         v.found_invalid = bad_seen;
         v.error_offset = bad_seen ? bad_offset : 32'd0;
         verdict_q.push_back(v);
         clear_string_state();
      end else if (cur_offset != '1) begin
         cur_offset = cur_offset + 32'd1;
      end
   endtask

   // drive one word, wait for it to be taken
   task automatic send_word(input logic [7:0] b, input logic is_last);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{data_byte: b, last_byte: is_last};
      do @(posedge clock); while (req_stall);
      predict_verdict(b, is_last);
      words_sent++;
   endtask

   task automatic send_pending();
      for (int i = 0; i < pending_bytes.size(); i++)
         send_word(pending_bytes[i], i == pending_bytes.size() - 1);
   endtask

   // drop valid, let every verdict come back and the pipeline settle
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_strict(input logic v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      strict_cfg = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // random string: mostly well-formed sequences, some corrupt, cut short or junk
   task automatic build_random_string(input int max_seqs);
      int         nseq;
      int         kind;
      logic [7:0] lead;
      logic [7:0] seq[$];
      pending_bytes = {};
      nseq = $urandom_range(1, max_seqs);
      for (int i = 0; i < nseq; i++) begin
         seq = {};
         kind = $urandom_range(0, 9);
         case (kind)
            0, 1, 2: seq.push_back(8'($urandom_range(8'h00, 8'h7F)));
            3: begin
               seq.push_back(8'($urandom_range(8'hC2, 8'hDF)));
               seq.push_back(cont_byte());
            end
            4, 5: begin
               seq.push_back(8'($urandom_range(8'hE1, 8'hEF)));
               seq.push_back(cont_byte());
               seq.push_back(cont_byte());
            end
            6: begin
               seq.push_back(8'($urandom_range(8'hF1, 8'hF3)));
               seq.push_back(cont_byte());
               seq.push_back(cont_byte());
               seq.push_back(cont_byte());
            end
            7: begin
               // leads with a range rule on the second byte, both sides of the edge
               case ($urandom_range(0, 2))
                  0: lead = 8'hE0;
                  1: lead = 8'hF0;
                  default: lead = 8'hF4;
               endcase
               seq.push_back(lead);
               seq.push_back(cont_byte());
               seq.push_back(cont_byte());
               if (lead != 8'hE0) seq.push_back(cont_byte());
            end
            8: begin
               // leads that depend on mode or are always bad
               case ($urandom_range(0, 3))
                  0: seq.push_back(cont_byte());
                  1: seq.push_back(8'($urandom_range(8'hC0, 8'hC1)));
                  2: seq.push_back(8'($urandom_range(8'hF5, 8'hF7)));
                  default: seq.push_back(8'($urandom_range(8'hF8, 8'hFF)));
               endcase
            end
            default: seq.push_back(8'($urandom_range(0, 255)));
         endcase
         // corrupt a trailing byte now and then
         if (seq.size() > 1 && $urandom_range(0, 9) == 0)
            seq[$urandom_range(1, seq.size() - 1)] = 8'($urandom_range(0, 255));
         // cut the sequence short now and then
         if (seq.size() > 1 && $urandom_range(0, 11) == 0)
            seq = seq[0:$urandom_range(0, seq.size() - 2)];
         pending_bytes = {pending_bytes, seq};
      end
   endtask

   task automatic run_random_strings(input int target);
      int stop_at;
      stop_at = words_sent + target;
      while (words_sent < stop_at) begin
         build_random_string(8);
         send_pending();
      end
   endtask

   // strict mode: every always-bad case and the range rules
   task automatic test_directed_strict();
      write_strict(1'b1);
      pending_bytes = {8'h00};
      send_pending();
      pending_bytes = {8'h41, 8'hE0, 8'h9F, 8'h80};
      send_pending();
      pending_bytes = {8'hF4, 8'h90};
      send_pending();
      pending_bytes = {8'hF0, 8'h8F};
      send_pending();
      pending_bytes = {8'hC1};
      send_pending();
      pending_bytes = {8'hF5};
      send_pending();
      pending_bytes = {8'h7F, 8'hE2, 8'h82};
      send_pending();
      pending_bytes = {8'hF4, 8'h8F, 8'hBF, 8'hBF};
      send_pending();
      pending_bytes = {8'hFF};
      send_pending();
      wait_idle();
   endtask

   // relaxed mode: stray continuation and f8..ff taken, bad continuation, c0 lead
   task automatic test_directed_relaxed();
      write_strict(1'b0);
      pending_bytes = {8'h80, 8'hFF, 8'hC3, 8'h41};
      send_pending();
      pending_bytes = {8'hC0};
      send_pending();
      wait_idle();
   endtask

   task automatic test_random_relaxed();
      write_strict(1'b0);
      run_random_strings(180);
      wait_idle();
   endtask

   task automatic test_random_strict();
      write_strict(1'b1);
      run_random_strings(180);
      wait_idle();
   endtask

   // no gaps and no stalls on either side
   task automatic test_random_back_to_back();
      write_strict(1'($urandom_range(0, 1)));
      quiet_run = 1'b1;
      run_random_strings(190);
      quiet_run = 1'b0;
      wait_idle();
   endtask

   // result side stall pattern
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            if (!quiet_run && $urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
      end
   end

   // compare each taken verdict with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (verdict_q.size() == 0) begin
            $error("verdict with none pending: found_invalid %0b error_offset %0d",
                   rsp_data.found_invalid, rsp_data.error_offset);
            fail_count++;
         end else begin
            want_verdict = verdict_q.pop_front();
            if (rsp_data.found_invalid !== want_verdict.found_invalid) begin
               $error("found_invalid: expected %0b, got %0b",
                      want_verdict.found_invalid, rsp_data.found_invalid);
               fail_count++;
            end
            if (rsp_data.error_offset !== want_verdict.error_offset) begin
               $error("error_offset: expected %0d, got %0d",
                      want_verdict.error_offset, rsp_data.error_offset);
               fail_count++;
            end
         end
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = 1'b0;
      strict_cfg = CSR_STRICT_RESET;
      clear_string_state();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_strict();
      test_directed_relaxed();
      test_random_relaxed();
      test_random_strict();
      test_random_back_to_back();

      repeat (10) @(posedge clock);
      if (fail_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule

// ----- utf8_stream_validator_top.f -----
hdl/u8v_pkg.sv
hdl/u8v_in_stage.sv
hdl/u8v_check.sv
hdl/utf8_stream_validator_top.sv
sim/tb_utf8_stream_validator_top.sv
